// ===== design/lcdns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, codes and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam int WAIT_W          = 20;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [WAIT_W-1:0] PULSE_RST   = 20'd2000;
  localparam logic [WAIT_W-1:0] SETTLE_RST  = 20'd5000;
  localparam logic [WAIT_W-1:0] CLEAR_RST   = 20'd20000;
  localparam logic [WAIT_W-1:0] POWERUP_RST = 20'd100000;

  localparam logic [1:0] REG_PULSE   = 2'd0;
  localparam logic [1:0] REG_SETTLE  = 2'd1;
  localparam logic [1:0] REG_CLEAR   = 2'd2;
  localparam logic [1:0] REG_POWERUP = 2'd3;

  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_DATA   = 3'd2;
  localparam logic [2:0] ACT_CURSOR = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [7:0] CMD_WAKE_A   = 8'h33;
  localparam logic [7:0] CMD_WAKE_B   = 8'h32;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] LINE0_BASE   = 8'h80;
  localparam logic [7:0] LINE1_BASE   = 8'hC0;

  localparam logic [2:0] IDX_FIRST = 3'd0;
  localparam logic [2:0] IDX_CLEAR = 3'd5;

  localparam logic [2:0] SUB_HI_EN  = 3'd0;
  localparam logic [2:0] SUB_HI_DIS = 3'd1;
  localparam logic [2:0] SUB_LO_EN  = 3'd2;
  localparam logic [2:0] SUB_SETTLE = 3'd4;

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_CLEAR,
    JOB_INIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] value;
  } job_t;

  typedef enum logic [1:0] {
    SQ_POWER,
    SQ_BYTE,
    SQ_EXTRA
  } seq_state_t;

  typedef struct packed {
    logic [WAIT_W-1:0] pulse;
    logic [WAIT_W-1:0] settle;
    logic [WAIT_W-1:0] clear;
    logic [WAIT_W-1:0] powerup;
  } wait_cfg_t;

  typedef struct packed {
    logic              rs;
    logic              en;
    logic [3:0]        nib;
    logic [WAIT_W-1:0] wait_ticks;
    logic              last;
  } step_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_WAKE_A;
      3'd1:    b = CMD_WAKE_B;
      3'd2:    b = CMD_FUNC_SET;
      3'd3:    b = CMD_DISP_ON;
      3'd4:    b = CMD_ENTRY;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

// ===== design/lcdns_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts requests, decodes them into jobs and holds one in a stage register.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  logic [7:0]        byte_value,
  input  logic              row,
  input  logic [5:0]        column,
  output logic              job_valid,
  input  logic              job_ready,
  output lcdns_pkg::job_t   job
);
  import lcdns_pkg::*;

  logic slot_valid;
  logic slot_valid_next;
  job_t slot_job;
  job_t dec_job;
  logic dec_ok;
  logic accept;

  always_comb begin
    dec_ok        = 1'b1;
    dec_job.kind  = JOB_BYTE;
    dec_job.rs    = 1'b0;
    dec_job.value = 8'h00;
    case (action)
      ACT_INIT: begin
        dec_job.kind = JOB_INIT;
      end
      ACT_CMD: begin
        dec_job.value = byte_value;
      end
      ACT_DATA: begin
        dec_job.rs    = 1'b1;
        dec_job.value = byte_value;
      end
      ACT_CURSOR: begin
        dec_job.value = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, column};
      end
      ACT_CLEAR: begin
        dec_job.kind = JOB_CLEAR;
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  assign in_ready  = !slot_valid || job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = slot_valid;
  assign job       = slot_job;

  always_comb begin
    slot_valid_next = slot_valid;
    if (accept) begin
      slot_valid_next = dec_ok;
    end else if (slot_valid && job_ready) begin
      slot_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_job <= dec_job;
    end
  end

endmodule

// ===== design/lcdns_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_queue
// Short show-ahead job queue between the front and the step sequencer.
// ----------------------------------------------------------------------------
module lcdns_queue #(
  parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lcdns_pkg::job_t push_job,
  output logic            head_valid,
  input  logic            pop,
  output lcdns_pkg::job_t head_job
);
  import lcdns_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== design/lcdns_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdns_back
// Walks each job through its pin steps, one step per cycle into an output
// register while the output side takes them.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdns_pkg::wait_cfg_t cfg,
  input  logic                 job_valid,
  input  lcdns_pkg::job_t      job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcdns_pkg::step_t     step
);
  import lcdns_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  logic       active;
  logic       active_next;
  logic [2:0] sub;
  logic [2:0] sub_next;
  logic [2:0] idx;
  logic [2:0] idx_next;

  seq_state_t cur_state;
  logic [2:0] cur_sub;
  logic [2:0] cur_idx;
  logic [7:0] cur_byte;
  logic       advance;
  step_t      cur_step;

  assign cur_state = active ? state : ((job.kind == JOB_INIT) ? SQ_POWER : SQ_BYTE);
  assign cur_sub   = active ? sub : SUB_HI_EN;
  assign cur_idx   = active ? idx : ((job.kind == JOB_CLEAR) ? IDX_CLEAR : IDX_FIRST);
  assign cur_byte  = (job.kind == JOB_BYTE) ? job.value : init_byte(cur_idx);
  assign advance   = job_valid && (!out_valid || out_ready);
  assign job_pop   = advance && cur_step.last;

  // step outputs
  always_comb begin
    cur_step.rs         = 1'b0;
    cur_step.en         = 1'b0;
    cur_step.nib        = 4'h0;
    cur_step.wait_ticks = cfg.pulse;
    cur_step.last       = 1'b0;
    case (cur_state)
      SQ_POWER: begin
        cur_step.wait_ticks = cfg.powerup;
      end
      SQ_BYTE: begin
        cur_step.rs  = (job.kind == JOB_BYTE) ? job.rs : 1'b0;
        cur_step.en  = (cur_sub == SUB_HI_EN) || (cur_sub == SUB_LO_EN);
        cur_step.nib = (cur_sub <= SUB_HI_DIS) ? cur_byte[7:4] : cur_byte[3:0];
        if (cur_sub == SUB_SETTLE) begin
          cur_step.wait_ticks = cfg.settle;
          cur_step.last       = (job.kind == JOB_BYTE);
        end
      end
      SQ_EXTRA: begin
        cur_step.nib        = CMD_CLEAR[3:0];
        cur_step.wait_ticks = cfg.clear;
        cur_step.last       = 1'b1;
      end
      default: begin
        cur_step.last = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next  = cur_state;
    sub_next    = cur_sub;
    idx_next    = cur_idx;
    active_next = active;
    if (advance) begin
      active_next = !cur_step.last;
      case (cur_state)
        SQ_POWER: begin
          state_next = SQ_BYTE;
          sub_next   = SUB_HI_EN;
          idx_next   = IDX_FIRST;
        end
        SQ_BYTE: begin
          if (cur_sub == SUB_SETTLE) begin
            sub_next = SUB_HI_EN;
            if (cur_idx == IDX_CLEAR) begin
              state_next = SQ_EXTRA;
            end else begin
              idx_next = cur_idx + 1'b1;
            end
          end else begin
            sub_next = cur_sub + 1'b1;
          end
        end
        SQ_EXTRA: begin
          state_next = SQ_BYTE;
        end
        default: begin
          state_next = SQ_BYTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_BYTE;
      active    <= 1'b0;
      sub       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      sub    <= sub_next;
      idx    <= idx_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step <= cur_step;
    end
  end

endmodule

// ===== design/char_lcd_nibble_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_unit
// Character LCD 4-bit bus sequencer: turns requests into pin-state steps.
// ----------------------------------------------------------------------------
// Each accepted request becomes a run of steps on the output channel, one
// step per cycle while the output side takes them: five steps for a command,
// data or set-cursor request, six for clear, 32 for init. The step sequencer
// sets that rate; the decode stage and a job queue of QUEUE_DEPTH entries in
// front of it keep taking requests while earlier ones are still stepping.
// Action codes 5 to 7 are taken and give no steps. The four wait registers
// sit at byte addresses 0, 4, 8 and 12 and hold 20 bits each.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_unit #(
  parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdns_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdns_pkg::DATA_W-1:0] pwdata,
  output logic [lcdns_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   action,
  input  logic [7:0]                   byte_value,
  input  logic                         row,
  input  logic [5:0]                   column,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         reg_select,
  output logic                         enable,
  output logic [3:0]                   nibble,
  output logic [lcdns_pkg::WAIT_W-1:0] wait_ticks,
  output logic                         last
);
  import lcdns_pkg::*;

  wait_cfg_t cfg;
  logic      cfg_write;
  logic      fr_valid;
  logic      fr_ready;
  job_t      fr_job;
  logic      head_valid;
  job_t      head_job;
  logic      job_pop;
  step_t     step;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse   <= PULSE_RST;
      cfg.settle  <= SETTLE_RST;
      cfg.clear   <= CLEAR_RST;
      cfg.powerup <= POWERUP_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PULSE:   cfg.pulse   <= pwdata[WAIT_W-1:0];
        REG_SETTLE:  cfg.settle  <= pwdata[WAIT_W-1:0];
        REG_CLEAR:   cfg.clear   <= pwdata[WAIT_W-1:0];
        REG_POWERUP: cfg.powerup <= pwdata[WAIT_W-1:0];
        default:     cfg.pulse   <= cfg.pulse;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PULSE:   prdata = DATA_W'(cfg.pulse);
      REG_SETTLE:  prdata = DATA_W'(cfg.settle);
      REG_CLEAR:   prdata = DATA_W'(cfg.clear);
      REG_POWERUP: prdata = DATA_W'(cfg.powerup);
      default:     prdata = '0;
    endcase
  end

  lcdns_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .job_valid  (fr_valid),
    .job_ready  (fr_ready),
    .job        (fr_job)
  );

  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_job   (fr_job),
    .head_valid (head_valid),
    .pop        (job_pop),
    .head_job   (head_job)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .step      (step)
  );

  assign reg_select = step.rs;
  assign enable     = step.en;
  assign nibble     = step.nib;
  assign wait_ticks = step.wait_ticks;
  assign last       = step.last;

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> head_valid)
    else $error("job popped from an empty queue");

  a_pop_gives_last: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> out_valid && last)
    else $error("job retired without a final step");

  a_strobe_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable |-> !last)
    else $error("request ended with enable high");

endmodule

// ===== verif/char_lcd_nibble_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_unit_tb
// Self-checking bench for the character LCD 4-bit bus sequencer.
// ----------------------------------------------------------------------------
// Requests go in over valid/ready with random gaps. Every accepted request is
// expanded here into the pin steps it must produce: init, command, data, set
// cursor, clear, and the spare codes that produce nothing. Each step taken
// from the output channel is compared field by field with the oldest pending
// step. The wait registers are programmed over APB between phases, read back,
// and swept through zero, full scale and random values. The output side
// stalls at random, except during one phase of unbroken flow.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_unit_tb;
  import lcdns_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 24;
  localparam int RESET_CYCLES = 11;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] value;
    logic       line;
    logic [5:0] col;
  } lcd_request_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        action;
  logic [7:0]        byte_value;
  logic              row;
  logic [5:0]        column;
  logic              out_valid;
  logic              out_ready;
  logic              reg_select;
  logic              enable;
  logic [3:0]        nibble;
  logic [WAIT_W-1:0] wait_ticks;
  logic              last;

  step_t     pending_steps[$];
  wait_cfg_t waits;
  logic      steady_flow;
  int        mismatches;
  int        requests_taken;
  int        inits_taken;
  int        ignored_taken;
  int        steps_checked;
  int        settings_used;
  int        cycles;

  char_lcd_nibble_sequencer_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .enable     (enable),
    .nibble     (nibble),
    .wait_ticks (wait_ticks),
    .last       (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d steps outstanding", cycles,
               pending_steps.size());
      $display("[char_lcd_nibble_sequencer_unit] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void push_step(logic rs, logic en, logic [3:0] nib,
                                    logic [WAIT_W-1:0] ticks);
    step_t s;
    s.rs = rs;
    s.en = en;
    s.nib = nib;
    s.wait_ticks = ticks;
    s.last = 1'b0;
    pending_steps.push_back(s);
  endfunction

  // high nibble first, enable pulse around each nibble, then settle
  function automatic void push_byte(logic rs, logic [7:0] b);
    push_step(rs, 1'b1, b[7:4], waits.pulse);
    push_step(rs, 1'b0, b[7:4], waits.pulse);
    push_step(rs, 1'b1, b[3:0], waits.pulse);
    push_step(rs, 1'b0, b[3:0], waits.pulse);
    push_step(rs, 1'b0, b[3:0], waits.settle);
  endfunction

  function automatic void push_clear();
    push_byte(1'b0, CMD_CLEAR);
    push_step(1'b0, 1'b0, CMD_CLEAR[3:0], waits.clear);
  endfunction

  function automatic void expand_request(lcd_request_t r);
    int    before_cnt;
    step_t tail;
    before_cnt = pending_steps.size();
    case (r.act)
      ACT_INIT: begin
        push_step(1'b0, 1'b0, 4'h0, waits.powerup);
        push_byte(1'b0, CMD_WAKE_A);
        push_byte(1'b0, CMD_WAKE_B);
        push_byte(1'b0, CMD_FUNC_SET);
        push_byte(1'b0, CMD_DISP_ON);
        push_byte(1'b0, CMD_ENTRY);
        push_clear();
      end
      ACT_CMD:    push_byte(1'b0, r.value);
      ACT_DATA:   push_byte(1'b1, r.value);
      ACT_CURSOR: push_byte(1'b0, (r.line ? LINE1_BASE : LINE0_BASE) + {2'b00, r.col});
      ACT_CLEAR:  push_clear();
      default: ;
    endcase
    if (pending_steps.size() > before_cnt) begin
      tail = pending_steps.pop_back();
      tail.last = 1'b1;
      pending_steps.push_back(tail);
    end
  endfunction

  // record requests first so a step can never race its own expectation
  always @(posedge clk) begin
    step_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expand_request('{act: action, value: byte_value, line: row, col: column});
        requests_taken++;
        if (action == ACT_INIT) inits_taken++;
        if (action >= ACT_SPARE_FIRST) ignored_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_steps.size() == 0) begin
          $error("step with nothing pending: rs %0h en %0h nib %0h wait %0h last %0h",
                 reg_select, enable, nibble, wait_ticks, last);
          mismatches++;
        end else begin
          want = pending_steps.pop_front();
          check_field("reg_select", want.rs, reg_select);
          check_field("enable", want.en, enable);
          check_field("nibble", want.nib, nibble);
          check_field("wait_ticks", want.wait_ticks, wait_ticks);
          check_field("last", want.last, last);
          steps_checked++;
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (steady_flow || hold == 0) begin
        out_ready <= 1'b1;
        if (!steady_flow) hold = pick_gap();
      end else begin
        out_ready <= 1'b0;
        hold--;
      end
    end
  end

  task automatic send_request(lcd_request_t r);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= r.act;
    byte_value <= r.value;
    row        <= r.line;
    column     <= r.col;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off new requests until every pending step is out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(logic [1:0] idx, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PULSE:   waits.pulse = data[WAIT_W-1:0];
      REG_SETTLE:  waits.settle = data[WAIT_W-1:0];
      REG_CLEAR:   waits.clear = data[WAIT_W-1:0];
      REG_POWERUP: waits.powerup = data[WAIT_W-1:0];
      default: ;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    check_field("prdata", data[WAIT_W-1:0], got[WAIT_W-1:0]);
  endtask

  task automatic program_waits(logic [DATA_W-1:0] pulse, logic [DATA_W-1:0] settle,
                               logic [DATA_W-1:0] clr, logic [DATA_W-1:0] powerup);
    drain_pipeline();
    program_reg(REG_PULSE, pulse);
    program_reg(REG_SETTLE, settle);
    program_reg(REG_CLEAR, clr);
    program_reg(REG_POWERUP, powerup);
    settings_used++;
  endtask

  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int           pick;
    r.value = $urandom_range(0, 255);
    r.line  = $urandom_range(0, 1);
    r.col   = $urandom_range(0, 63);
    pick    = $urandom_range(0, 99);
    if (pick < 5)       r.act = ACT_INIT;
    else if (pick < 30) r.act = ACT_CMD;
    else if (pick < 60) r.act = ACT_DATA;
    else if (pick < 80) r.act = ACT_CURSOR;
    else if (pick < 92) r.act = ACT_CLEAR;
    else r.act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_wait_word();
    logic [DATA_W-1:0] w;
    int                pick;
    w    = $urandom;
    pick = $urandom_range(0, 3);
    if (pick == 0) w[WAIT_W-1:0] = '0;
    else if (pick == 1) w[WAIT_W-1:0] = '1;
    return w;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic send_each_kind();
    send_request('{act: ACT_INIT, value: 8'h00, line: 1'b0, col: 6'd0});
    send_request('{act: ACT_CMD, value: 8'hC3, line: 1'b1, col: 6'd21});
    send_request('{act: ACT_DATA, value: 8'h3C, line: 1'b0, col: 6'd42});
    send_request('{act: ACT_CURSOR, value: 8'h99, line: 1'b1, col: 6'd5});
    send_request('{act: ACT_CLEAR, value: 8'hFF, line: 1'b1, col: 6'd63});
  endtask

  task automatic test_directed_reset_waits();
    send_request('{act: ACT_INIT, value: 8'h00, line: 1'b0, col: 6'd0});
    send_request('{act: ACT_CMD, value: 8'h00, line: 1'b0, col: 6'd0});
    send_request('{act: ACT_CMD, value: 8'hFF, line: 1'b1, col: 6'd63});
    send_request('{act: ACT_DATA, value: 8'h00, line: 1'b1, col: 6'd63});
    send_request('{act: ACT_DATA, value: 8'hFF, line: 1'b0, col: 6'd0});
    send_request('{act: ACT_DATA, value: 8'hA5, line: 1'b1, col: 6'd42});
    send_request('{act: ACT_CMD, value: 8'h5A, line: 1'b0, col: 6'd21});
    send_request('{act: ACT_CURSOR, value: 8'hFF, line: 1'b0, col: 6'd0});
    send_request('{act: ACT_CURSOR, value: 8'h00, line: 1'b0, col: 6'd63});
    send_request('{act: ACT_CURSOR, value: 8'h55, line: 1'b1, col: 6'd0});
    send_request('{act: ACT_CURSOR, value: 8'hAA, line: 1'b1, col: 6'd63});
    send_request('{act: ACT_CLEAR, value: 8'h7E, line: 1'b1, col: 6'd9});
    send_request('{act: ACT_SPARE_FIRST, value: 8'hFF, line: 1'b1, col: 6'd63});
    send_request('{act: 3'd6, value: 8'h00, line: 1'b0, col: 6'd0});
    send_request('{act: ACT_SPARE_LAST, value: 8'h81, line: 1'b1, col: 6'd33});
    send_request('{act: ACT_DATA, value: 8'h7E, line: 1'b1, col: 6'd63});
    send_request('{act: ACT_INIT, value: 8'hFF, line: 1'b1, col: 6'd63});
  endtask

  task automatic test_zero_waits();
    program_waits('0, '0, '0, '0);
    send_each_kind();
    run_random(10);
  endtask

  task automatic test_full_scale_waits();
    program_waits('1, '1, '1, '1);
    send_each_kind();
    run_random(10);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    repeat (phases) begin
      program_waits(random_wait_word(), random_wait_word(), random_wait_word(),
                    random_wait_word());
      run_random(per_phase);
    end
  endtask

  task automatic test_steady_flow();
    program_waits($urandom, $urandom, $urandom, $urandom);
    steady_flow = 1'b1;
    run_random(40);
    drain_pipeline();
    steady_flow = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    action         = ACT_INIT;
    byte_value     = '0;
    row            = 1'b0;
    column         = '0;
    out_ready      = 1'b0;
    steady_flow    = 1'b0;
    mismatches     = 0;
    requests_taken = 0;
    inits_taken    = 0;
    ignored_taken  = 0;
    steps_checked  = 0;
    settings_used  = 1;
    cycles         = 0;
    waits          = '{pulse: PULSE_RST, settle: SETTLE_RST, clear: CLEAR_RST,
                       powerup: POWERUP_RST};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_reset_waits();
    test_zero_waits();
    test_full_scale_waits();
    test_random_phases(5, 57);
    test_steady_flow();
    drain_pipeline();

    $display("run: %0d requests (%0d init, %0d spare codes), %0d steps checked",
             requests_taken, inits_taken, ignored_taken, steps_checked);
    $display("run: %0d wait settings incl. reset, zero and full scale, %0d cycles",
             settings_used, cycles);
    if (mismatches == 0) begin
      $display("[char_lcd_nibble_sequencer_unit] OK");
    end else begin
      $display("[char_lcd_nibble_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lcdns_pkg.sv
design/lcdns_front.sv
design/lcdns_queue.sv
design/lcdns_back.sv
design/char_lcd_nibble_sequencer_unit.sv
verif/char_lcd_nibble_sequencer_unit_tb.sv
